### src/ourx_pkg.sv
// ----------------------------------------------------------------------------
// ourx_pkg
// Shared types and constants for the oversampled receive-line front end.
// ----------------------------------------------------------------------------
package ourx_pkg;

   // Register widths and indexes
   localparam int CSR_DATA_W  = 6;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_TICKS = 1'd1;

   localparam logic       LINE_MODE_RESET = 1'b0;
   localparam logic [5:0] BIT_TICKS_RESET = 6'd12;

   localparam logic MODE_UART   = 1'b0;
   localparam logic MODE_FILTER = 1'b1;

   // Receiver phase codes
   localparam logic [3:0] PHASE_IDLE    = 4'd0;
   localparam logic [3:0] PHASE_START   = 4'd1;
   localparam logic [3:0] PHASE_CONFIRM = 4'd2;
   localparam logic [3:0] PHASE_DATA0   = 4'd3;
   localparam logic [3:0] PHASE_DATA7   = 4'd10;
   localparam logic [3:0] PHASE_STOP    = 4'd11;

   // Integrator limit in filter mode
   localparam logic [5:0] INTEG_TOP = 6'd10;

   typedef struct packed {
      logic       line_mode;
      logic [5:0] bit_ticks;
   } cfg_type;

   typedef struct packed {
      logic       event_res;
      logic [7:0] data_byte;
      logic       filtered_level;
   } result_type;

endpackage

### src/ourx_if.sv
// ----------------------------------------------------------------------------
// ourx_if
// Valid/ready channels for line samples and receive results.
// ----------------------------------------------------------------------------
interface ourx_req_if;
   logic valid;
   logic ready;
   logic line_sample;

   modport source (output valid, output line_sample, input ready);
   modport sink   (input valid, input line_sample, output ready);
endinterface

interface ourx_rsp_if;
   logic       valid;
   logic       ready;
   logic       event_res;
   logic [7:0] data_byte;
   logic       filtered_level;

   modport source (output valid, output event_res, output data_byte,
                   output filtered_level, input ready);
   modport sink   (input valid, input event_res, input data_byte,
                   input filtered_level, output ready);
endinterface

### src/ourx_csr.sv
// ----------------------------------------------------------------------------
// ourx_csr
// Configuration registers: line mode and bit interval.
// ----------------------------------------------------------------------------
module ourx_csr
   import ourx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LINE_MODE: cfg_in.line_mode = csr_wdata[0];
            CSR_BIT_TICKS: cfg_in.bit_ticks = csr_wdata[5:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_mode <= LINE_MODE_RESET;
         cfg_ff.bit_ticks <= BIT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/ourx_core.sv
// ----------------------------------------------------------------------------
// ourx_core
// Receiver/filter state and its one-sample update.
// ----------------------------------------------------------------------------
module ourx_core
   import ourx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic       line_sample,
   output result_type result
);

   logic [5:0] tick_timer_ff, tick_timer_in;
   logic [3:0] phase_ff, phase_in;
   logic [7:0] shift_byte_ff, shift_byte_in;

   logic [5:0] integ;
   logic [3:0] phase_inc;
   logic [3:0] bit_pos;
   logic [5:0] stop_wait;

   always_comb begin
      tick_timer_in  = tick_timer_ff;
      phase_in       = phase_ff;
      shift_byte_in  = shift_byte_ff;
      result         = '0;
      integ          = tick_timer_ff;
      phase_inc      = phase_ff + 4'd1;
      bit_pos        = phase_inc - PHASE_DATA0;
      stop_wait      = (cfg.bit_ticks != 6'd0) ? cfg.bit_ticks - 6'd1 : 6'd0;

      if (cfg.line_mode == MODE_FILTER) begin
         // Saturating integrator; values above the top only decay
         if (line_sample) begin
            if (tick_timer_ff < INTEG_TOP) integ = tick_timer_ff + 6'd1;
         end else if (tick_timer_ff != 6'd0) begin
            integ = tick_timer_ff - 6'd1;
         end
         tick_timer_in = integ;
         if (integ == 6'd0 && phase_ff != 4'd0) begin
            phase_in = 4'd0;
         end else if (integ >= INTEG_TOP && phase_ff != 4'd1) begin
            phase_in = 4'd1;
            result.event_res = 1'b1;
         end
         result.filtered_level = (phase_in == 4'd1);
      end else if (tick_timer_ff != 6'd0) begin
         tick_timer_in = tick_timer_ff - 6'd1;
      end else begin
         tick_timer_in = cfg.bit_ticks;
         phase_in      = phase_inc;
         unique case (phase_inc) inside
            PHASE_START: begin
               tick_timer_in = 6'd0;
               if (line_sample) phase_in = PHASE_IDLE;
            end
            PHASE_CONFIRM: begin
               if (line_sample) begin
                  tick_timer_in = 6'd0;
                  phase_in      = PHASE_IDLE;
               end else begin
                  shift_byte_in = 8'd0;
               end
            end
            [PHASE_DATA0:PHASE_DATA7]: begin
               if (line_sample) shift_byte_in[bit_pos[2:0]] = 1'b1;
               if (phase_inc == PHASE_DATA7) tick_timer_in = stop_wait;
            end
            default: begin
               // Stop bit, wrap or out-of-range phase: drop back to idle
               if (phase_inc == PHASE_STOP && line_sample) begin
                  result.event_res = 1'b1;
                  result.data_byte = shift_byte_ff;
               end
               tick_timer_in = 6'd0;
               phase_in      = PHASE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_timer_ff <= 6'd0;
         phase_ff      <= PHASE_IDLE;
         shift_byte_ff <= 8'd0;
      end else if (step) begin
         tick_timer_ff <= tick_timer_in;
         phase_ff      <= phase_in;
         shift_byte_ff <= shift_byte_in;
      end
   end

endmodule

### src/oversampled_uart_receiver_top.sv
// Latency: a result appears in the cycle after its sample is accepted.
// Throughput: one sample per clock unless results stall; the single result
//   register set by the one-pass state update is the only stage.
// Reset: synchronous, active high; clears receiver state and the result
//   valid flag, and restores the configuration (line_mode 0, bit_ticks 12).
// ----------------------------------------------------------------------------
// oversampled_uart_receiver_top
// 8N1 receiver with oversampled line input, or integrating line filter.
// ----------------------------------------------------------------------------
module oversampled_uart_receiver_top
   import ourx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   ourx_req_if.sink               req_ch,
   ourx_rsp_if.source             rsp_ch,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       step;

   // Hold configuration written between frames
   ourx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Accept a request whenever the result register is empty or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign step         = req_ch.valid && req_ch.ready;

   // Advance the receiver/filter state by one sample per accepted request
   ourx_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .step        (step),
      .line_sample (req_ch.line_sample),
      .result      (result)
   );

   // Every request yields exactly one result; hold it until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.event_res      = result_ff.event_res;
   assign rsp_ch.data_byte      = result_ff.data_byte;
   assign rsp_ch.filtered_level = result_ff.filtered_level;

endmodule

### tb/tb_oversampled_uart_receiver_top.sv
// ----------------------------------------------------------------------------
// tb_oversampled_uart_receiver_top
// Self-checking bench for the oversampled line receiver and integrating filter.
// Line samples go in as requests on a valid/ready channel. Every accepted
// sample is run through a cycle-exact predictor of the receiver, and each
// result is checked field by field against the oldest prediction. The run
// covers clean and broken 8N1 frames, filter-mode runs, mode and baud
// changes with live state, and random traffic under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_oversampled_uart_receiver_top;
   import ourx_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Filter mode keeps the debounced level in the phase register
   localparam logic [3:0] LEVEL_LOW  = 4'd0;
   localparam logic [3:0] LEVEL_HIGH = 4'd1;

   logic                   clock;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ourx_req_if req_ch ();
   ourx_rsp_if rsp_ch ();

   oversampled_uart_receiver_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the configuration and receiver state
   logic       mode_cfg  = LINE_MODE_RESET;
   logic [5:0] ticks_cfg = BIT_TICKS_RESET;
   logic [5:0] rx_timer  = '0;
   logic [3:0] rx_phase  = PHASE_IDLE;
   logic [7:0] rx_shift  = '0;

   result_type pending_results[$];

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int sample_count  = 0;
   int result_count  = 0;
   int event_count   = 0;
   int error_count   = 0;
   int mismatch_count = 0;

   // -------------------------------------------------------------------------
   // Clock and run limit
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stop the run with an error if it is still going at this limit.
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Predictor: advance the state by one line sample, return the result
   // -------------------------------------------------------------------------
   function automatic result_type predict_line_result(input logic sample);
      result_type res;
      res = '0;
      if (mode_cfg == MODE_FILTER) begin
         // Saturating integrator; it never climbs past the top but may
         // bleed down from a larger value left by the receiver.
         if (sample) begin
            if (rx_timer < INTEG_TOP) rx_timer = rx_timer + 6'd1;
         end else if (rx_timer != 6'd0) begin
            rx_timer = rx_timer - 6'd1;
         end
         if (rx_timer == 6'd0 && rx_phase != LEVEL_LOW) begin
            rx_phase = LEVEL_LOW;
         end else if (rx_timer > INTEG_TOP - 6'd1 && rx_phase != LEVEL_HIGH) begin
            rx_phase = LEVEL_HIGH;
            res.event_res = 1'b1;
         end
         res.filtered_level = (rx_phase == LEVEL_HIGH);
      end else if (rx_timer != 6'd0) begin
         rx_timer = rx_timer - 6'd1;
      end else begin
         rx_timer = ticks_cfg;
         rx_phase = rx_phase + 4'd1;
         if (rx_phase == PHASE_START) begin
            rx_timer = '0;
            if (sample) rx_phase = PHASE_IDLE;
         end else if (rx_phase == PHASE_CONFIRM) begin
            if (sample) begin
               rx_timer = '0;
               rx_phase = PHASE_IDLE;
            end else begin
               rx_shift = '0;
            end
         end else if (rx_phase >= PHASE_DATA0 && rx_phase <= PHASE_DATA7) begin
            if (sample) rx_shift[rx_phase - PHASE_DATA0] = 1'b1;
            // Stop-bit wait is one tick shorter
            if (rx_phase == PHASE_DATA7)
               rx_timer = (ticks_cfg != 6'd0) ? ticks_cfg - 6'd1 : 6'd0;
         end else begin
            if (rx_phase == PHASE_STOP && sample) begin
               res.event_res = 1'b1;
               res.data_byte = rx_shift;
            end
            rx_timer = '0;
            rx_phase = PHASE_IDLE;
         end
      end
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Result checker and receiver back-pressure
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.event_res      = rsp_ch.event_res;
            got.data_byte      = rsp_ch.data_byte;
            got.filtered_level = rsp_ch.filtered_level;
            result_count++;
            if (pending_results.size() == 0) begin
               error_count++;
               if (mismatch_count++ < 10)
                  $display("[%0t] result with no sample pending: ev=%0b data=%02h lvl=%0b",
                           $realtime, got.event_res, got.data_byte, got.filtered_level);
            end else begin
               want = pending_results.pop_front();
               if (want.event_res) event_count++;
               if (got.event_res !== want.event_res || got.data_byte !== want.data_byte ||
                   got.filtered_level !== want.filtered_level) begin
                  error_count++;
                  if (mismatch_count++ < 10) begin
                     $display("[%0t] mismatch: expected ev=%0b data=%02h lvl=%0b",
                              $realtime, want.event_res, want.data_byte,
                              want.filtered_level);
                     $display("          actual   ev=%0b data=%02h lvl=%0b",
                              got.event_res, got.data_byte, got.filtered_level);
                  end
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Shared drivers
   // -------------------------------------------------------------------------

   // Offer one sample, idling first at random; predict on acceptance.
   task automatic send_sample(input logic sample);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.line_sample <= sample;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(predict_line_result(sample));
      sample_count++;
   endtask

   task automatic send_run(input logic level, input int count);
      repeat (count) send_sample(level);
   endtask

   // Drop valid and wait until every predicted result has been collected.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Register writes only land with the block idle.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (index == CSR_LINE_MODE) mode_cfg = value[0];
      else ticks_cfg = value[5:0];
   endtask

   // One 8N1 frame, each bit held for 'period' samples. A low stop bit is
   // held for a single sample so the line returns high right away.
   task automatic send_frame(input logic [7:0] data, input logic stop_bit,
                             input int period);
      send_run(1'b0, period);
      for (int k = 0; k < 8; k++) send_run(data[k], period);
      send_run(stop_bit, stop_bit ? period : 1);
      send_run(1'b1, $urandom_range(4, 1));
   endtask

   function automatic int line_period();
      return int'(ticks_cfg) + 1;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Receive at the reset baud setting without touching any register.
   task automatic test_reset_baud();
      send_run(1'b1, 3);
      send_frame(8'hA5, 1'b1, line_period());
   endtask

   // Lowest tested bit interval (2) with all-zero, all-one and single-bit bytes.
   task automatic test_byte_extremes();
      write_csr(CSR_BIT_TICKS, 6'd2);
      send_frame(8'h00, 1'b1, line_period());
      send_frame(8'hFF, 1'b1, line_period());
      send_frame(8'h80, 1'b1, line_period());
      send_frame(8'h01, 1'b1, line_period());
   endtask

   // Single low glitches and a start dropped at confirmation; then a low stop bit.
   task automatic test_false_start_and_bad_stop();
      send_run(1'b0, 1);
      send_run(1'b1, 2);
      send_run(1'b0, 1);
      send_run(1'b1, 1);
      send_frame(8'h3C, 1'b0, line_period());
      send_run(1'b1, 4);
      send_frame(8'hC3, 1'b1, line_period());
   endtask

   // Slowest baud: one long frame.
   task automatic test_slow_baud();
      write_csr(CSR_BIT_TICKS, 6'd63);
      send_frame(8'h5A, 1'b1, line_period());
      write_csr(CSR_BIT_TICKS, 6'd2);
   endtask

   // Integrator saturation, glitch rejection, rise events and falls.
   task automatic test_filter_integrator();
      write_csr(CSR_LINE_MODE, 6'(MODE_FILTER));
      send_run(1'b1, 12);
      send_run(1'b0, 3);
      send_run(1'b1, 5);
      send_run(1'b0, 12);
      for (int k = 0; k < 10; k++) send_sample(k[0]);
      send_run(1'b1, 11);
      send_run(1'b0, 11);
      write_csr(CSR_LINE_MODE, 6'(MODE_UART));
   endtask

   // Switch modes with live state so each mode reads the other's leftovers.
   task automatic test_mode_switch_live_state();
      // Large receiver countdown handed to the filter as an integrator above ten
      write_csr(CSR_BIT_TICKS, 6'd63);
      send_run(1'b0, 5);
      write_csr(CSR_LINE_MODE, 6'(MODE_FILTER));
      send_run(1'b1, 3);
      send_run(1'b0, 64);
      send_run(1'b1, 10);
      // Filter level and integrator handed back to the receiver
      write_csr(CSR_LINE_MODE, 6'(MODE_UART));
      write_csr(CSR_BIT_TICKS, 6'd2);
      send_run(1'b0, 14);
      send_run(1'b1, 20);
      // Confirmed start with a small countdown; filter drains it to zero
      send_run(1'b0, 3);
      write_csr(CSR_LINE_MODE, 6'(MODE_FILTER));
      send_run(1'b0, 2);
      send_run(1'b1, 4);
      write_csr(CSR_LINE_MODE, 6'(MODE_UART));
      send_run(1'b1, 30);
      // Baud change in the middle of a frame
      send_run(1'b0, 7);
      write_csr(CSR_BIT_TICKS, 6'd4);
      send_run(1'b1, 40);
   endtask

   // Mostly well-formed frames with random content, some noise and breakage.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count);
      int first;
      int pick;
      int period;
      first = sample_count;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      while (sample_count - first < count) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_frame(8'($urandom), ($urandom_range(9) != 0), line_period());
         end else if (pick < 70) begin
            // Baud mismatch or a low stop bit
            period = line_period() + $urandom_range(2) - 1;
            if (period < 2) period = 2;
            send_frame(8'($urandom), 1'($urandom_range(1)), period);
         end else if (pick < 78) begin
            repeat ($urandom_range(30, 5)) send_sample(1'($urandom_range(1)));
         end else if (pick < 86) begin
            repeat ($urandom_range(4, 1)) begin
               send_run(1'b0, 1);
               send_run(1'b1, $urandom_range(3, 1));
            end
         end else if (pick < 93) begin
            if ($urandom_range(7) == 0) write_csr(CSR_BIT_TICKS, 6'($urandom_range(20, 7)));
            else write_csr(CSR_BIT_TICKS, 6'($urandom_range(6, 2)));
         end else begin
            write_csr(CSR_LINE_MODE, 6'(MODE_FILTER));
            repeat ($urandom_range(8, 3))
               send_run(1'($urandom_range(1)), $urandom_range(14, 1));
            write_csr(CSR_LINE_MODE, 6'(MODE_UART));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      csr_write          <= 1'b0;
      csr_index          <= CSR_LINE_MODE;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.line_sample <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_baud();
      test_byte_extremes();
      test_false_start_and_bad_stop();
      test_slow_baud();
      test_filter_integrator();
      test_mode_switch_live_state();
      test_random_traffic(15, 80, 100);
      test_random_traffic(80, 15, 100);
      test_random_traffic(0, 0, 100);

      // Collect the tail, then give any stray result time to show up
      drain_results();
      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) error_count++;

      $display("Ran %0d line samples through receiver and filter modes, baud 2..63.",
               sample_count);
      $display("Checked %0d results, %0d of them events; %0d failures.",
               result_count, event_count, error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
src/ourx_pkg.sv
src/ourx_if.sv
src/ourx_csr.sv
src/ourx_core.sv
src/oversampled_uart_receiver_top.sv
tb/tb_oversampled_uart_receiver_top.sv
